// ===== sv/clma_pkg.sv =====
// Shared types, constants and helpers for the command latency metrics block.
`timescale 1ns / 1ps
`default_nettype none
package clma_pkg;

    // Moving-average weights rounded to Q0.32
    localparam logic [31:0] W_MEDIAN  = 32'd21474836;
    localparam logic [31:0] W_HIGH    = 32'd429497;
    localparam logic [31:0] W_EXTREME = 32'd42950;

    localparam int NUM_AVGS  = 3;
    localparam int NUM_TERMS = 3;
    localparam int MUL_STEPS = NUM_AVGS * NUM_TERMS;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);

    // Hit ratio: 16 quotient bits plus one bit for exactly 1.0
    localparam int Q_BITS   = 16;
    localparam int RATIO_W  = Q_BITS + 1;
    localparam int QCNT_W   = $clog2(Q_BITS);
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << Q_BITS;

    typedef enum logic [1:0] {
        AVG_MEDIAN  = 2'd0,
        AVG_HIGH    = 2'd1,
        AVG_EXTREME = 2'd2
    } avg_sel_t;

    typedef enum logic [1:0] {
        TERM_LO     = 2'd0,
        TERM_HI     = 2'd1,
        TERM_SAMPLE = 2'd2
    } term_t;

    function automatic avg_sel_t step_avg(input logic [STEP_W-1:0] step);
        avg_sel_t a;
        case (step)
            STEP_W'(0), STEP_W'(1), STEP_W'(2): a = AVG_MEDIAN;
            STEP_W'(3), STEP_W'(4), STEP_W'(5): a = AVG_HIGH;
            default:                            a = AVG_EXTREME;
        endcase
        return a;
    endfunction

    function automatic term_t step_term(input logic [STEP_W-1:0] step);
        term_t t;
        case (step)
            STEP_W'(0), STEP_W'(3), STEP_W'(6): t = TERM_LO;
            STEP_W'(1), STEP_W'(4), STEP_W'(7): t = TERM_HI;
            default:                            t = TERM_SAMPLE;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] avg_weight(input avg_sel_t a);
        logic [31:0] w;
        unique case (a)
            AVG_MEDIAN:  w = W_MEDIAN;
            AVG_HIGH:    w = W_HIGH;
            AVG_EXTREME: w = W_EXTREME;
            default:     w = W_EXTREME;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/clma_mul.sv =====
// Shared 32x32 multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module clma_mul (
    input  wire logic        aclk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= 64'(op_a) * 64'(op_b);
    end

    assign product = product_reg;

endmodule
`default_nettype wire

// ===== sv/clma_div.sv =====
// Serial restoring divider for the Q1.16 hit ratio, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module clma_div
    import clma_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [63:0]        num,
    input  wire logic [63:0]        den,
    output logic                    done,
    output logic [RATIO_W-1:0]      ratio
);

    logic              busy_reg;
    logic              done_reg;
    logic              zero_reg;
    logic              sat_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       den_reg;
    logic [Q_BITS-1:0] q_reg;

    logic [64:0] shifted;
    logic        ge;

    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num;
                den_reg  <= den;
                q_reg    <= '0;
                zero_reg <= (den == 64'd0);
                sat_reg  <= (den != 64'd0) && (num >= den);
            end else if (busy_reg) begin
                if (zero_reg || sat_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (ge) begin
                        rem_reg <= 64'(shifted - {1'b0, den_reg});
                    end else begin
                        rem_reg <= shifted[63:0];
                    end
                    q_reg   <= {q_reg[Q_BITS-2:0], ge};
                    cnt_reg <= cnt_reg + QCNT_W'(1);
                    if (cnt_reg == QCNT_W'(Q_BITS - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done  = done_reg;
    assign ratio = zero_reg ? '0 : (sat_reg ? RATIO_ONE : {1'b0, q_reg});

endmodule
`default_nettype wire

// ===== sv/command_latency_metrics_accumulator.sv =====
// Command latency statistics: counters, three moving averages, peak, hit ratio and slow-log slot.
// Takes one completed-command request and returns one result with the updated statistics.
// While the result side keeps up, each request passes through these steps before the next is accepted:
// - acceptance in the idle state;
// - the multiply steps, in which a single shared 32x32 multiplier forms the three products of each of
//   the three moving averages;
// - the serial divider that yields the hit ratio, sixteen quotient bits and a done strobe;
// - loading the output register.
// When the command count has wrapped to zero or hits are not below commands, the divider
// finishes without forming any quotient bits and the next request is accepted sooner. s_tready is high only while the
// sequencer is idle. A result waiting in the output register does not block the next request
// until that request is done and needs the output register.
// The slow threshold is written on the cfg channel, which is always ready.
`timescale 1ns / 1ps
`default_nettype none
module command_latency_metrics_accumulator
    import clma_pkg::*;
#(
    parameter int SLOW_LOG_DEPTH = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rx byte count [31:0], tx byte count [63:32], latency [95:64]
    input  wire logic [95:0]  s_tdata,
    // error flag [0], hit flag [1]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // command_total, error_total, hit_total, rx_byte_total, tx_byte_total, avg_median,
    // avg_high, avg_extreme (64 each), peak_latency (32), hit_ratio (17), slow_slot (7)
    output logic [567:0]      m_tdata,
    // slow_logged[0]
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    localparam int SLOT_W = (SLOW_LOG_DEPTH > 1) ? $clog2(SLOW_LOG_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOW_LOG_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;

    logic [31:0]       thresh_reg;
    logic [63:0]       cmd_reg, err_reg, hit_reg, rx_reg, tx_reg;
    logic [63:0]       med_reg, high_reg, ext_reg;
    logic [31:0]       peak_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [31:0]       lat_reg;
    logic              slow_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [STEP_W-1:0] step_reg;
    logic              mac_vld_reg;
    avg_sel_t          mac_avg_reg;
    term_t             mac_term_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;

    logic              m_tvalid_reg;
    logic [567:0]      m_tdata_reg;
    logic              m_tuser_reg;

    logic              s_fire;
    logic [31:0]       s_rx_len, s_tx_len, s_latency;
    logic              s_slow;

    avg_sel_t          iss_avg;
    term_t             iss_term;
    logic [63:0]       iss_val;
    logic [31:0]       mul_a;
    logic [63:0]       product;
    logic [63:0]       acc_base;
    logic signed [64:0] round_d;
    logic signed [64:0] round_c;

    logic              div_start;
    logic              div_done;
    logic [RATIO_W-1:0] div_ratio;
    logic              out_free;
    logic [SLOT_W+6:0] slot_ext;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign s_rx_len    = s_tdata[31:0];
    assign s_tx_len    = s_tdata[63:32];
    assign s_latency   = s_tdata[95:64];
    assign s_slow      = s_latency >= thresh_reg;
    assign cfg_ready   = 1'b1;

    // Operand selection for the product issued this cycle
    assign iss_avg  = step_avg(step_reg);
    assign iss_term = step_term(step_reg);

    always_comb begin
        case (iss_avg)
            AVG_MEDIAN: iss_val = med_reg;
            AVG_HIGH:   iss_val = high_reg;
            default:    iss_val = ext_reg;
        endcase
        case (iss_term)
            TERM_LO: mul_a = iss_val[31:0];
            TERM_HI: mul_a = iss_val[63:32];
            default: mul_a = lat_reg;
        endcase
    end

    clma_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (avg_weight(iss_avg)),
        .product (product)
    );

    // new = avg - hi*w + floor((2^31 - lo*w) / 2^32) + sample*w
    always_comb begin
        case (mac_avg_reg)
            AVG_MEDIAN: acc_base = med_reg;
            AVG_HIGH:   acc_base = high_reg;
            default:    acc_base = ext_reg;
        endcase
        round_d = 65'sd2147483648 - $signed({1'b0, product});
        round_c = round_d >>> 32;
        case (mac_term_reg)
            TERM_LO: acc_next = acc_base + round_c[63:0];
            TERM_HI: acc_next = acc_reg - product;
            default: acc_next = acc_reg + product;
        endcase
    end

    assign div_start = (state_reg == S_MUL) && (step_reg == STEP_W'(MUL_STEPS));
    assign out_free  = !m_tvalid_reg || m_tready;

    clma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (hit_reg),
        .den     (cmd_reg),
        .done    (div_done),
        .ratio   (div_ratio)
    );

    // Sequencer and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            mac_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mac_vld_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    step_reg <= '0;
                    if (s_fire) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (step_reg == STEP_W'(MUL_STEPS)) begin
                        state_reg <= S_DIV;
                    end else begin
                        mac_vld_reg <= 1'b1;
                        step_reg    <= step_reg + STEP_W'(1);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Statistics state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= 32'd10000;
            cmd_reg    <= '0;
            err_reg    <= '0;
            hit_reg    <= '0;
            rx_reg     <= '0;
            tx_reg     <= '0;
            med_reg    <= '0;
            high_reg   <= '0;
            ext_reg    <= '0;
            peak_reg   <= '0;
            pos_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            if (s_fire) begin
                cmd_reg <= cmd_reg + 64'd1;
                err_reg <= err_reg + 64'(s_tuser[0]);
                hit_reg <= hit_reg + 64'(s_tuser[1]);
                rx_reg  <= rx_reg + 64'(s_rx_len);
                tx_reg  <= tx_reg + 64'(s_tx_len);
                if (s_latency > peak_reg) begin
                    peak_reg <= s_latency;
                end
                if (s_slow) begin
                    pos_reg <= (pos_reg == SLOT_LAST) ? '0 : pos_reg + SLOT_W'(1);
                end
            end
            // Write back an average once its sample term is in
            if (mac_vld_reg && mac_term_reg == TERM_SAMPLE) begin
                case (mac_avg_reg)
                    AVG_MEDIAN: med_reg  <= acc_next;
                    AVG_HIGH:   high_reg <= acc_next;
                    default:    ext_reg  <= acc_next;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lat_reg  <= s_latency;
            slow_reg <= s_slow;
            slot_reg <= s_slow ? pos_reg : '0;
        end
        if (state_reg == S_MUL) begin
            mac_avg_reg  <= iss_avg;
            mac_term_reg <= iss_term;
        end
        if (mac_vld_reg) begin
            acc_reg <= acc_next;
        end
        if (div_done) begin
            ratio_reg <= div_ratio;
        end
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {slot_ext[6:0], ratio_reg, peak_reg, ext_reg, high_reg, med_reg,
                            tx_reg, rx_reg, hit_reg, err_reg, cmd_reg};
            m_tuser_reg <= slow_reg;
        end
    end

    assign slot_ext = {7'd0, slot_reg};

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
`default_nettype wire
